@@ hdl/mrtd_pkg.sv @@
// Shared constants, types and codes for the MMIO range table decoder.
package mrtd_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int ALIGN_SHIFT   = 16;
  localparam int ADDR_W        = 48;
  localparam int SIZE_W        = 40;
  localparam int KIND_W        = 2;
  localparam int FIDX_W        = 6;
  localparam int STAT_W        = 3;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int RND_W         = SIZE_W + 1;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [FIDX_W-1:0] fidx_t;
  typedef logic [RND_W-1:0]  rnd_t;

  localparam addr_t MMIO_BASE_RST = addr_t'(64'h0000_0000_4000_0000);
  localparam rnd_t  ALIGN_MASK    = rnd_t'((64'd1 << ALIGN_SHIFT) - 64'd1);

  typedef enum logic [KIND_W-1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_ASSIGN = 2'd1,
    KIND_FREE   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_MISS    = 3'd1,
    STAT_FULL    = 3'd2,
    STAT_INVALID = 3'd3,
    STAT_RANGE   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SLOT,
    S_PLACE,
    S_FREE_RD,
    S_FREE_CHK,
    S_DONE
  } state_t;

  // One table row: start and exclusive end
  typedef struct packed {
    addr_t lo;
    addr_t hi;
  } win_t;

  // Table port request from the sequencer
  typedef struct packed {
    logic we;
    idx_t waddr;
    idx_t raddr;
    win_t wdata;
  } tbl_req_t;

  typedef struct packed {
    status_t status;
    fidx_t   entry_index;
    addr_t   window_start;
    addr_t   window_end;
  } res_t;

endpackage

@@ hdl/mrtd_in_if.sv @@
// Request channel interface: valid/ready plus request payload.
interface mrtd_in_if import mrtd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [ADDR_W-1:0]   address;
  logic                auto_place;
  logic [SIZE_W-1:0]   window_size;
  logic [FIDX_W-1:0]   free_index;

  modport source (output valid, kind, address, auto_place, window_size, free_index,
                  input ready);
  modport sink   (input valid, kind, address, auto_place, window_size, free_index,
                  output ready);
endinterface

@@ hdl/mrtd_out_if.sv @@
// Result channel interface: valid/ready plus result payload.
interface mrtd_out_if import mrtd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [FIDX_W-1:0]   entry_index;
  logic [ADDR_W-1:0]   window_start;
  logic [ADDR_W-1:0]   window_end;

  modport source (output valid, status, entry_index, window_start, window_end,
                  input ready);
  modport sink   (input valid, status, entry_index, window_start, window_end,
                  output ready);
endinterface

@@ hdl/mrtd_table.sv @@
// Window table memory: one write port, one registered read port.
module mrtd_table import mrtd_pkg::*; (
  input  logic     clk,
  input  tbl_req_t req,
  output win_t     rdata
);

  win_t mem [TABLE_ENTRIES];
  win_t rdata_r;

  // Write the placed window
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Register the read row
  always_ff @(posedge clk) begin
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/mrtd_ctrl.sv @@
// Sequencer with the shared window comparator and placement adder.
module mrtd_ctrl import mrtd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  mrtd_in_if.sink   in_ch,
  mrtd_out_if.source out_ch,
  input  addr_t     mmio_base,
  output tbl_req_t  tbl_req,
  input  win_t      tbl_rdata
);

  localparam cnt_t LAST_IDX = cnt_t'(TABLE_ENTRIES);
  localparam cnt_t FULL_CNT = cnt_t'(TABLE_ENTRIES - 1);

  state_t state_r, state_nxt;
  addr_t  addr_r, addr_nxt;
  logic   autop_r, autop_nxt;
  rnd_t   rnd_r, rnd_nxt;
  fidx_t  fidx_r, fidx_nxt;
  cnt_t   idx_r, idx_nxt;
  logic   pend_r, pend_nxt;
  idx_t   pidx_r, pidx_nxt;
  idx_t   slot_r, slot_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  cnt_t   vcount_r, vcount_nxt;
  addr_t  bump_r, bump_nxt;
  logic   bump_started_r, bump_started_nxt;
  res_t   res_r, res_nxt;
  logic   out_valid_r, out_valid_nxt;
  res_t   out_r, out_nxt;

  logic            in_xfer;
  logic            hit;
  logic            full;
  logic            free_ok;
  logic            out_free;
  addr_t           start_sel;
  logic [ADDR_W:0] sum;
  rnd_t            rnd_in;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign full     = vcount_r >= FULL_CNT;

  // Round the requested size up to the alignment
  assign rnd_in = ({1'b0, in_ch.window_size} + ALIGN_MASK) & ~ALIGN_MASK;

  // Shared comparator: does the pending row hold the lookup address
  assign hit = pend_r && valid_r[pidx_r] &&
               (addr_r >= tbl_rdata.lo) && (addr_r < tbl_rdata.hi);

  // Shared adder: window start plus rounded size
  assign start_sel = autop_r ? (bump_started_r ? bump_r : mmio_base) : addr_r;
  assign sum       = {1'b0, start_sel} + (ADDR_W + 1)'(rnd_r);

  assign free_ok = (int'(fidx_r) < TABLE_ENTRIES) && valid_r[idx_t'(fidx_r)];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (kind_t'(in_ch.kind))
            KIND_LOOKUP: state_nxt = S_SCAN;
            KIND_ASSIGN: state_nxt = S_SLOT;
            KIND_FREE:   state_nxt = S_FREE_RD;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (hit || (pend_r && idx_r == LAST_IDX)) begin
          state_nxt = S_DONE;
        end
      end
      S_SLOT: begin
        if (full) begin
          state_nxt = S_DONE;
        end else if (!valid_r[idx_r[IDX_W-1:0]]) begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE:    state_nxt = S_DONE;
      S_FREE_RD:  state_nxt = S_FREE_CHK;
      S_FREE_CHK: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Datapath, table port and result
  always_comb begin
    addr_nxt         = addr_r;
    autop_nxt        = autop_r;
    rnd_nxt          = rnd_r;
    fidx_nxt         = fidx_r;
    idx_nxt          = idx_r;
    pend_nxt         = 1'b0;
    pidx_nxt         = pidx_r;
    slot_nxt         = slot_r;
    valid_nxt        = valid_r;
    vcount_nxt       = vcount_r;
    bump_nxt         = bump_r;
    bump_started_nxt = bump_started_r;
    res_nxt          = res_r;
    out_nxt          = out_r;
    out_valid_nxt    = out_valid_r;

    tbl_req.we       = 1'b0;
    tbl_req.waddr    = slot_r;
    tbl_req.raddr    = idx_r[IDX_W-1:0];
    tbl_req.wdata.lo = start_sel;
    tbl_req.wdata.hi = sum[ADDR_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          addr_nxt  = in_ch.address;
          autop_nxt = in_ch.auto_place;
          rnd_nxt   = rnd_in;
          fidx_nxt  = in_ch.free_index;
          idx_nxt   = '0;
        end
      end
      S_SCAN: begin
        // Issue the next row while comparing the previous one
        if (idx_r < LAST_IDX) begin
          pend_nxt = 1'b1;
          pidx_nxt = idx_r[IDX_W-1:0];
          idx_nxt  = idx_r + cnt_t'(1);
        end
        if (hit) begin
          res_nxt.status       = STAT_OK;
          res_nxt.entry_index  = fidx_t'(pidx_r);
          res_nxt.window_start = tbl_rdata.lo;
          res_nxt.window_end   = tbl_rdata.hi;
        end else if (pend_r && idx_r == LAST_IDX) begin
          res_nxt.status       = STAT_MISS;
          res_nxt.entry_index  = '0;
          res_nxt.window_start = '0;
          res_nxt.window_end   = '0;
        end
      end
      S_SLOT: begin
        // Walk valid bits for the lowest free row
        if (full) begin
          res_nxt.status       = STAT_FULL;
          res_nxt.entry_index  = '0;
          res_nxt.window_start = '0;
          res_nxt.window_end   = '0;
        end else if (!valid_r[idx_r[IDX_W-1:0]]) begin
          slot_nxt = idx_r[IDX_W-1:0];
        end else begin
          idx_nxt = idx_r + cnt_t'(1);
        end
      end
      S_PLACE: begin
        if (autop_r) begin
          bump_started_nxt = 1'b1;
          bump_nxt         = start_sel;
        end
        if (sum[ADDR_W]) begin
          res_nxt.status       = STAT_RANGE;
          res_nxt.entry_index  = '0;
          res_nxt.window_start = start_sel;
          res_nxt.window_end   = '0;
        end else begin
          tbl_req.we        = 1'b1;
          valid_nxt[slot_r] = 1'b1;
          vcount_nxt        = vcount_r + cnt_t'(1);
          if (autop_r) begin
            bump_nxt = sum[ADDR_W-1:0];
          end
          res_nxt.status       = STAT_OK;
          res_nxt.entry_index  = fidx_t'(slot_r);
          res_nxt.window_start = start_sel;
          res_nxt.window_end   = sum[ADDR_W-1:0];
        end
      end
      S_FREE_RD: begin
        tbl_req.raddr = idx_t'(fidx_r);
      end
      S_FREE_CHK: begin
        res_nxt.entry_index = fidx_r;
        if (free_ok) begin
          valid_nxt[idx_t'(fidx_r)] = 1'b0;
          vcount_nxt                = vcount_r - cnt_t'(1);
          res_nxt.status            = STAT_OK;
          res_nxt.window_start      = tbl_rdata.lo;
          res_nxt.window_end        = tbl_rdata.hi;
        end else begin
          res_nxt.status       = STAT_INVALID;
          res_nxt.window_start = '0;
          res_nxt.window_end   = '0;
        end
      end
      default: begin
      end
    endcase

    // Output register: drop on transfer, load a finished result
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == S_DONE && out_free) begin
      out_nxt       = res_r;
      out_valid_nxt = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      pend_r         <= 1'b0;
      valid_r        <= '0;
      vcount_r       <= '0;
      bump_r         <= '0;
      bump_started_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      pend_r         <= pend_nxt;
      valid_r        <= valid_nxt;
      vcount_r       <= vcount_nxt;
      bump_r         <= bump_nxt;
      bump_started_r <= bump_started_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    autop_r <= autop_nxt;
    rnd_r   <= rnd_nxt;
    fidx_r  <= fidx_nxt;
    idx_r   <= idx_nxt;
    pidx_r  <= pidx_nxt;
    slot_r  <= slot_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_r.status;
  assign out_ch.entry_index  = out_r.entry_index;
  assign out_ch.window_start = out_r.window_start;
  assign out_ch.window_end   = out_r.window_end;

endmodule

@@ hdl/mmio_range_table_decoder_top.sv @@
// Top level of the MMIO range table decoder with bump placement.
//
//   port     | dir | handshake      | carries
//   in_ch    | in  | valid / ready  | kind, address, auto_place, window_size, free_index
//   out_ch   | out | valid / ready  | status, entry_index, window_start, window_end
//   cfg_*    | in  | write enable   | mmio_base
//
// Lookup: the single table read port feeds one comparator, one row per cycle.
// Assign walks the valid bits to the lowest free row and places the window there,
// or ends with a full status on a full table; free reads the row, then checks it.
// Reset clears the valid bits, the bump pointer and loads mmio_base with 0x4000_0000;
// table rows are not cleared. A stalled result holds in the output register while
// the next transfer is taken and worked on; that one waits in its final state.
module mmio_range_table_decoder_top import mrtd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  mrtd_in_if.sink    in_ch,
  mrtd_out_if.source out_ch,
  input  logic       cfg_we,
  input  addr_t      cfg_wdata
);

  addr_t    mmio_base_r;
  tbl_req_t tbl_req;
  win_t     tbl_rdata;

  // Hold the automatic placement base
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mmio_base_r <= MMIO_BASE_RST;
    end else if (cfg_we) begin
      mmio_base_r <= cfg_wdata;
    end
  end

  mrtd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mmio_base (mmio_base_r),
    .tbl_req   (tbl_req),
    .tbl_rdata (tbl_rdata)
  );

  mrtd_table u_table (
    .clk   (clk),
    .req   (tbl_req),
    .rdata (tbl_rdata)
  );

  // A miss or a full table carries no window
  a_miss_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status == STAT_MISS || out_ch.status == STAT_FULL) |->
      out_ch.entry_index == '0 && out_ch.window_start == '0 && out_ch.window_end == '0)
    else $error("miss or full result carries a window");

  // A good result never has its end below its start
  a_ok_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == STAT_OK |-> out_ch.window_end >= out_ch.window_start)
    else $error("window end below start");

  // Out of range assigns report no end
  a_range_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == STAT_RANGE |->
      out_ch.window_end == '0 && out_ch.entry_index == '0)
    else $error("range fault carries an end or index");

  // No transfer is taken while a request is in progress
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.kind != KIND_NONE |=> !in_ch.ready)
    else $error("request taken while busy");

endmodule

@@ verif/mmio_range_table_decoder_top_tb.sv @@
// Self-checking testbench for the MMIO range table decoder: shadow table, random traffic.
module mmio_range_table_decoder_top_tb import mrtd_pkg::*; ();

  localparam int    WATCHDOG_LIMIT = 2000;
  localparam int    DRAIN_PAD      = 100;
  localparam addr_t ADDR_TOP       = '1;
  localparam addr_t AUTO_BASE      = addr_t'(64'h0000_FF00_0000_0000);

  typedef struct {
    kind_t kind;
    addr_t address;
    logic  auto_place;
    size_t window_size;
    fidx_t free_index;
  } req_item_t;

  logic  clk = 1'b0;
  logic  rst_n;
  logic  cfg_we;
  addr_t cfg_wdata;

  mrtd_in_if  in_ch ();
  mrtd_out_if out_ch ();

  mmio_range_table_decoder_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shadow copy of the window table, bump allocator and base register
  addr_t tbl_lo    [TABLE_ENTRIES];
  addr_t tbl_hi    [TABLE_ENTRIES];
  bit    tbl_valid [TABLE_ENTRIES] = '{default: 1'b0};
  addr_t bump_ptr    = '0;
  bit    bump_live   = 1'b0;
  addr_t base_shadow = MMIO_BASE_RST;

  req_item_t pending_reqs[$];
  res_t      expected_results[$];
  int        issued_cnt   = 0;
  int        accepted_cnt = 0;
  int        results_seen = 0;
  int        mismatches   = 0;
  addr_t     gen_bump     = AUTO_BASE;

  // Apply one request to the shadow table; return 1 when it yields a result
  function automatic bit window_table_apply(input req_item_t it, output res_t r);
    logic [63:0] amask;
    logic [63:0] rounded;
    logic [63:0] start;
    logic [63:0] stop;
    int          used;
    int          slot;
    r = '0;
    amask = (64'd1 << ALIGN_SHIFT) - 64'd1;
    case (it.kind)
      KIND_LOOKUP: begin
        r.status = STAT_MISS;
        // Scan downward so the lowest matching entry wins
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
          if (tbl_valid[i] && it.address >= tbl_lo[i] && it.address < tbl_hi[i]) begin
            r.status       = STAT_OK;
            r.entry_index  = fidx_t'(i);
            r.window_start = tbl_lo[i];
            r.window_end   = tbl_hi[i];
          end
        end
      end
      KIND_ASSIGN: begin
        rounded = (64'(it.window_size) + amask) & ~amask;
        used = 0;
        slot = -1;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
          if (tbl_valid[i]) used++;
          else slot = i;
        end
        if (used >= TABLE_ENTRIES - 1 || slot < 0) begin
          r.status = STAT_FULL;
        end else begin
          if (it.auto_place) begin
            if (!bump_live) begin
              bump_ptr  = base_shadow;
              bump_live = 1'b1;
            end
            start = 64'(bump_ptr);
          end else begin
            start = 64'(it.address);
          end
          stop = start + rounded;
          if (stop > 64'(ADDR_TOP)) begin
            r.status       = STAT_RANGE;
            r.window_start = addr_t'(start);
          end else begin
            tbl_lo[slot]    = addr_t'(start);
            tbl_hi[slot]    = addr_t'(stop);
            tbl_valid[slot] = 1'b1;
            if (it.auto_place) bump_ptr = addr_t'(stop);
            r.status       = STAT_OK;
            r.entry_index  = fidx_t'(slot);
            r.window_start = addr_t'(start);
            r.window_end   = addr_t'(stop);
          end
        end
      end
      KIND_FREE: begin
        r.entry_index = it.free_index;
        if (tbl_valid[it.free_index]) begin
          tbl_valid[it.free_index] = 1'b0;
          r.status       = STAT_OK;
          r.window_start = tbl_lo[it.free_index];
          r.window_end   = tbl_hi[it.free_index];
        end else begin
          r.status = STAT_INVALID;
        end
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // Driver: offer queued requests in bursts with random gaps
  req_item_t cur_req;
  res_t      pred_res;
  int        burst_left = 0;
  int        gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      // Predict on every accepted transfer
      if (in_ch.valid && in_ch.ready) begin
        accepted_cnt++;
        if (window_table_apply(cur_req, pred_res)) expected_results.push_back(pred_res);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          in_ch.kind        <= cur_req.kind;
          in_ch.address     <= cur_req.address;
          in_ch.auto_place  <= cur_req.auto_place;
          in_ch.window_size <= cur_req.window_size;
          in_ch.free_index  <= cur_req.free_index;
          in_ch.valid       <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(0, 15);
            case ($urandom_range(0, 9))
              0, 1, 2, 3: gap_left = 0;
              4:          gap_left = 30;
              default:    gap_left = $urandom_range(1, 10);
            endcase
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer and drive the stall pattern
  res_t want;
  int   hold_left      = 0;
  bit   long_hold_done = 1'b0;
  int   stall_mode     = 0;
  int   mode_left      = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d, entry_index %0d", out_ch.status,
                 out_ch.entry_index);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            mismatches++;
          end
          if (out_ch.entry_index !== want.entry_index) begin
            $error("entry_index: expected %0d, got %0d", want.entry_index,
                   out_ch.entry_index);
            mismatches++;
          end
          if (out_ch.window_start !== want.window_start) begin
            $error("window_start: expected %h, got %h", want.window_start,
                   out_ch.window_start);
            mismatches++;
          end
          if (out_ch.window_end !== want.window_end) begin
            $error("window_end: expected %h, got %h", want.window_end, out_ch.window_end);
            mismatches++;
          end
        end
      end
      // Hold off once for a long stretch while requests keep coming
      if (!long_hold_done && results_seen >= 300 && pending_reqs.size() > 20) begin
        hold_left      = 400;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(20, 120);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
          2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= ~out_ch.ready;
        endcase
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic req_item_t mk_req(kind_t k, addr_t a, logic ap, size_t s, fidx_t f);
    req_item_t it;
    it.kind        = k;
    it.address     = a;
    it.auto_place  = ap;
    it.window_size = s;
    it.free_index  = f;
    return it;
  endfunction

  task automatic post_req(input req_item_t it);
    pending_reqs.push_back(it);
    issued_cnt++;
  endtask

  // Wait until every request is taken and answered, then let the block settle
  task automatic wait_idle();
    while (accepted_cnt != issued_cnt || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic write_base(input addr_t v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    base_shadow = v;
  endtask

  // Queue random requests with the given lookup/assign/free weights
  task automatic post_random(input int n, input int w_look, input int w_asg,
                             input int w_free);
    req_item_t   it;
    int          pick;
    int          p;
    logic [63:0] rounded;
    for (int k = 0; k < n; k++) begin
      it = mk_req(KIND_NONE, addr_t'({$urandom, $urandom}), 1'($urandom),
                  size_t'({$urandom, $urandom}), fidx_t'($urandom));
      pick = $urandom_range(1, w_look + w_asg + w_free);
      p    = $urandom_range(0, 99);
      if ($urandom_range(0, 49) == 0) begin
        it.kind = KIND_NONE;
      end else if (pick <= w_look) begin
        it.kind = KIND_LOOKUP;
        // Aim most lookups at live windows and their edges
        if (p < 30)      it.address = addr_t'($urandom_range(0, 32'h3F_FFFF));
        else if (p < 45) it.address = addr_t'(($urandom_range(0, 63) << 16)
                                              - $urandom_range(0, 1));
        else if (p < 80) it.address = gen_bump - addr_t'($urandom_range(0, 32'hFF_FFFF));
      end else if (pick <= w_look + w_asg) begin
        it.kind = KIND_ASSIGN;
        if (it.auto_place) begin
          if (p < 60)      it.window_size = size_t'($urandom_range(0, 32'h3_FFFF));
          else if (p < 90) it.window_size = size_t'($urandom_range(0, 32'hFFFF));
          else             it.window_size = size_t'($urandom_range(0, 32'hFF_FFFF));
          rounded  = (64'(it.window_size) + 64'hFFFF) & ~64'hFFFF;
          gen_bump = gen_bump + addr_t'(rounded);
        end else begin
          if (p < 45)      it.address = addr_t'($urandom_range(0, 63) << 16);
          else if (p < 85) it.address = addr_t'($urandom_range(0, 32'h3F_FFFF));
          p = $urandom_range(0, 99);
          if (p < 60)      it.window_size = size_t'($urandom_range(0, 32'h3_FFFF));
          else if (p < 85) it.window_size = size_t'($urandom_range(0, 32'hFFFF));
        end
      end else begin
        it.kind = KIND_FREE;
      end
      post_req(it);
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.kind         = KIND_LOOKUP;
    in_ch.address      = '0;
    in_ch.auto_place   = 1'b0;
    in_ch.window_size  = '0;
    in_ch.free_index   = '0;
    out_ch.ready       = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extremes first; the last value is what the first automatic placement loads
    write_base(ADDR_TOP);
    write_base('0);
    write_base(AUTO_BASE);

    // Empty table, idle kind, first automatic placement out of space
    post_req(mk_req(KIND_LOOKUP, '0, 1'b0, '0, '0));
    post_req(mk_req(KIND_LOOKUP, ADDR_TOP, 1'b1, '1, '1));
    post_req(mk_req(KIND_FREE, '0, 1'b0, '0, '0));
    post_req(mk_req(KIND_FREE, ADDR_TOP, 1'b1, '1, '1));
    post_req(mk_req(KIND_NONE, ADDR_TOP, 1'b1, '1, '1));
    post_req(mk_req(KIND_ASSIGN, '0, 1'b1, '1, '0));
    // Zero size is stored but never matches
    post_req(mk_req(KIND_ASSIGN, '0, 1'b1, '0, '0));
    post_req(mk_req(KIND_LOOKUP, AUTO_BASE, 1'b0, '0, '0));
    post_req(mk_req(KIND_ASSIGN, '0, 1'b1, size_t'(1), '0));
    post_req(mk_req(KIND_LOOKUP, AUTO_BASE, 1'b0, '0, '0));
    // Fixed windows, half-open edges, overlap resolved to the lowest entry
    post_req(mk_req(KIND_ASSIGN, '0, 1'b0, size_t'(40'h1_0000), '0));
    post_req(mk_req(KIND_LOOKUP, addr_t'(48'hFFFF), 1'b0, '0, '0));
    post_req(mk_req(KIND_LOOKUP, addr_t'(48'h1_0000), 1'b0, '0, '0));
    post_req(mk_req(KIND_ASSIGN, addr_t'(48'h8000), 1'b0, size_t'(40'h1_0001), '0));
    post_req(mk_req(KIND_LOOKUP, addr_t'(48'h8000), 1'b0, '0, '0));
    post_req(mk_req(KIND_LOOKUP, addr_t'(48'h2_7FFF), 1'b0, '0, '0));
    // Top of the address space
    post_req(mk_req(KIND_ASSIGN, ADDR_TOP, 1'b0, '0, '0));
    post_req(mk_req(KIND_ASSIGN, ADDR_TOP, 1'b0, size_t'(1), '0));
    post_req(mk_req(KIND_ASSIGN, addr_t'(48'hFFFF_FFFF_0000), 1'b0, size_t'(40'hFFFF), '0));
    post_req(mk_req(KIND_ASSIGN, addr_t'(48'hFFFF_FFFE_0000), 1'b0, size_t'(40'hFFFF), '0));
    // Free, double free, reuse of the lowest free entry
    post_req(mk_req(KIND_FREE, '0, 1'b0, '0, fidx_t'(2)));
    post_req(mk_req(KIND_FREE, '0, 1'b0, '0, fidx_t'(2)));
    post_req(mk_req(KIND_LOOKUP, addr_t'(48'h100), 1'b0, '0, '0));
    post_req(mk_req(KIND_ASSIGN, addr_t'(48'h100), 1'b0, size_t'(40'h20), '0));
    post_req(mk_req(KIND_LOOKUP, addr_t'(48'h8000), 1'b0, '0, '0));

    // Random phases; the base changes between them but the bump pointer keeps going
    post_random(250, 50, 30, 20);
    write_base('0);
    post_random(250, 40, 15, 45);
    write_base(ADDR_TOP);
    post_random(250, 15, 80, 5);
    write_base(addr_t'({$urandom, $urandom}));
    post_random(250, 20, 10, 70);
    write_base(MMIO_BASE_RST);
    post_random(250, 45, 30, 25);

    wait_idle();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
